// ===== design/pwsf_pkg.sv =====
`default_nettype none
package pwsf_pkg;

	localparam int CFG_AW = 6;
	localparam int CFG_DW = 64;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_DOT   = 8'h2E;

	// fixed word "config", last character in low byte
	localparam logic [47:0] WORD_CFG     = 48'h636F_6E66_6967;
	localparam int          WORD_CFG_LEN = 6;

	localparam logic [63:0] RST_PAT_A     = 64'h0000_002F_686F_6D65;
	localparam logic [3:0]  RST_PAT_A_LEN = 4'd5;
	localparam logic [63:0] RST_PAT_B     = 64'h0000_2F77_656C_6C6F;
	localparam logic [3:0]  RST_PAT_B_LEN = 4'd6;
	localparam logic [1:0]  RST_IN_USE    = 2'd2;

	typedef enum logic [2:0] {
		REG_PAT_A     = 3'd0,
		REG_PAT_A_LEN = 3'd1,
		REG_PAT_B     = 3'd2,
		REG_PAT_B_LEN = 3'd3,
		REG_IN_USE    = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [63:0] pattern_a;
		logic [3:0]  pattern_a_len;
		logic [63:0] pattern_b;
		logic [3:0]  pattern_b_len;
		logic [1:0]  patterns_in_use;
	} cfg_t;

	// per-position byte compare against both patterns and the fixed word
	typedef struct packed {
		logic a;
		logic b;
		logic w;
	} eq_t;

	function automatic eq_t byte_cmp(input logic [7:0] b_in, input logic [7:0] pa,
		input logic [7:0] pb, input logic [7:0] pw);
		eq_t r;
		r.a = (b_in == pa);
		r.b = (b_in == pb);
		r.w = (b_in == pw);
		return r;
	endfunction

	function automatic logic [7:0] word_byte(input int pos);
		return 8'(WORD_CFG >> (8 * pos));
	endfunction

endpackage
`default_nettype wire

// ===== design/pwsf_regs.sv =====
`default_nettype none
module pwsf_regs (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire [pwsf_pkg::CFG_AW-1:0]   paddr,
	input  wire [pwsf_pkg::CFG_DW-1:0]   pwdata,
	output logic [pwsf_pkg::CFG_DW-1:0]  prdata,
	output logic                         pready,
	output pwsf_pkg::cfg_t               cfg
);
	import pwsf_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[CFG_AW-1:3]);
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern_a       <= RST_PAT_A;
			cfg_q.pattern_a_len   <= RST_PAT_A_LEN;
			cfg_q.pattern_b       <= RST_PAT_B;
			cfg_q.pattern_b_len   <= RST_PAT_B_LEN;
			cfg_q.patterns_in_use <= RST_IN_USE;
		end else if (wr_en) begin
			unique case (idx)
				REG_PAT_A:     cfg_q.pattern_a       <= pwdata;
				REG_PAT_A_LEN: cfg_q.pattern_a_len   <= pwdata[3:0];
				REG_PAT_B:     cfg_q.pattern_b       <= pwdata;
				REG_PAT_B_LEN: cfg_q.pattern_b_len   <= pwdata[3:0];
				REG_IN_USE:    cfg_q.patterns_in_use <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_PAT_A:     prdata = cfg_q.pattern_a;
			REG_PAT_A_LEN: prdata = {60'd0, cfg_q.pattern_a_len};
			REG_PAT_B:     prdata = cfg_q.pattern_b;
			REG_PAT_B_LEN: prdata = {60'd0, cfg_q.pattern_b_len};
			REG_IN_USE:    prdata = {62'd0, cfg_q.patterns_in_use};
			default:       prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

// ===== design/pwsf_cell.sv =====
`default_nettype none
module pwsf_cell (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          shift,
	input  wire          clr,
	input  wire  [7:0]   byte_in,
	input  wire  [7:0]   pat_a_byte,
	input  wire  [7:0]   pat_b_byte,
	input  wire  [7:0]   word_byte_in,
	output logic [7:0]   byte_q,
	output pwsf_pkg::eq_t eq
);
	import pwsf_pkg::*;

	// compare the byte entering this window position, then hold it for the next cell
	assign eq = byte_cmp(byte_in, pat_a_byte, pat_b_byte, word_byte_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (clr) begin
			byte_q <= '0;
		end else if (shift) begin
			byte_q <= byte_in;
		end
	end

endmodule
`default_nettype wire

// ===== design/path_whitelist_substring_filter.sv =====
`default_nettype none
// channel | handshake          | payload
// input   | in_valid, in_stall | ch
// output  | out_valid, out_stall| keep_path, whitelist_hit, config_seen
// config  | APB write/read     | pattern registers
//
// One byte per cycle if not stalled; each byte passes a row of byte cells that
// compare the window with both patterns and the word "config" in the same cycle.
// A NUL byte loads the single output register; its word appears in the next cycle.
// Input stalls only while a word sits in the output register and output stalls.
// arst_n clears the per-path state and the output valid, and loads reset patterns.
module path_whitelist_substring_filter #(
	parameter int MAX_PATTERN_BYTES = 8
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire  [7:0]                   ch,
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic                         keep_path,
	output logic                         whitelist_hit,
	output logic                         config_seen,
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire  [pwsf_pkg::CFG_AW-1:0]  paddr,
	input  wire  [pwsf_pkg::CFG_DW-1:0]  pwdata,
	output logic [pwsf_pkg::CFG_DW-1:0]  prdata,
	output logic                         pready
);
	import pwsf_pkg::*;

	localparam int MAXB = MAX_PATTERN_BYTES;
	localparam int CW   = $clog2(MAXB + 1);

	cfg_t cfg;

	logic [7:0]      win [MAXB];
	eq_t             eq_w [MAXB];
	logic [MAXB-1:0] eq_a, eq_b, eq_c, mask_a, mask_b, mask_c;

	logic          accept, shift, clr;
	logic [CW-1:0] count_q, valid_n, len_a, len_b;
	logic          hit_q, bad_q, fns_q;
	logic          use_a, use_b, match_a, match_b, match_w;
	logic          hit_fin, single, keep_n;
	logic          out_valid_q, keep_q, hit_o_q, cfg_o_q;

	pwsf_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;
	assign shift    = accept & (ch != CH_NUL);
	assign clr      = accept & (ch == CH_NUL);

	assign win[0] = ch;

	genvar j;
	generate
		for (j = 0; j < MAXB - 1; j++) begin : g_cell
			pwsf_cell u_cell (
				.clk          (clk),
				.arst_n       (arst_n),
				.shift        (shift),
				.clr          (clr),
				.byte_in      (win[j]),
				.pat_a_byte   (cfg.pattern_a[8*j +: 8]),
				.pat_b_byte   (cfg.pattern_b[8*j +: 8]),
				.word_byte_in (word_byte(j)),
				.byte_q       (win[j+1]),
				.eq           (eq_w[j])
			);
		end
	endgenerate

	// oldest window position has no cell after it
	assign eq_w[MAXB-1] = byte_cmp(win[MAXB-1], cfg.pattern_a[8*(MAXB-1) +: 8],
		cfg.pattern_b[8*(MAXB-1) +: 8], word_byte(MAXB-1));

	assign len_a = (cfg.pattern_a_len > 4'(MAXB)) ? CW'(MAXB) : CW'(cfg.pattern_a_len);
	assign len_b = (cfg.pattern_b_len > 4'(MAXB)) ? CW'(MAXB) : CW'(cfg.pattern_b_len);
	assign use_a = (cfg.patterns_in_use != 2'd0);
	assign use_b = cfg.patterns_in_use[1];

	assign valid_n = (count_q == CW'(MAXB)) ? CW'(MAXB) : CW'(count_q + 1'b1);

	always_comb begin
		for (int k = 0; k < MAXB; k++) begin
			eq_a[k]   = eq_w[k].a;
			eq_b[k]   = eq_w[k].b;
			eq_c[k]   = eq_w[k].w;
			mask_a[k] = (CW'(k) < len_a);
			mask_b[k] = (CW'(k) < len_b);
			mask_c[k] = (k < WORD_CFG_LEN);
		end
	end

	assign match_a = (len_a == '0) || ((valid_n >= len_a) && (&(eq_a | ~mask_a)));
	assign match_b = (len_b == '0) || ((valid_n >= len_b) && (&(eq_b | ~mask_b)));
	assign match_w = (valid_n >= CW'(WORD_CFG_LEN)) && (&(eq_c | ~mask_c));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			hit_q   <= 1'b0;
			bad_q   <= 1'b0;
			fns_q   <= 1'b0;
		end else if (clr) begin
			count_q <= '0;
			hit_q   <= 1'b0;
			bad_q   <= 1'b0;
			fns_q   <= 1'b0;
		end else if (shift) begin
			count_q <= valid_n;
			if (count_q == '0 && ch != CH_SLASH) fns_q <= 1'b1;
			if ((use_a && match_a) || (use_b && match_b)) hit_q <= 1'b1;
			if (match_w) bad_q <= 1'b1;
		end
	end

	// zero-length active pattern matches even an empty path
	assign hit_fin = hit_q | (use_a & (len_a == '0)) | (use_b & (len_b == '0));
	assign single  = (count_q == CW'(1)) && (win[1] == CH_DOT || win[1] == CH_SLASH);
	assign keep_n  = (hit_fin | fns_q | (count_q == '0)) & ~bad_q & ~single;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (clr) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (clr) begin
			keep_q  <= keep_n;
			hit_o_q <= hit_fin;
			cfg_o_q <= bad_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign keep_path     = keep_q;
	assign whitelist_hit = hit_o_q;
	assign config_seen   = cfg_o_q;

`ifndef SYNTH
	a_count_sat: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAXB))
		else $error("byte count beyond window size");

	a_nul_clears: assert property (@(posedge clk) disable iff (!arst_n)
		clr |=> (count_q == '0) && !hit_q && !bad_q && !fns_q)
		else $error("per-path state not cleared after end of path");

	a_nul_word: assert property (@(posedge clk) disable iff (!arst_n)
		clr |=> out_valid)
		else $error("end of path gave no output word");

	a_cfg_rejects: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(keep_path && config_seen))
		else $error("path kept although config occurred");

	a_no_word_lost: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> !accept)
		else $error("input taken while output word is blocked");
`endif

endmodule
`default_nettype wire
